/* sv/asfc_pkg.sv */
`default_nettype none

package asfc_pkg;

    localparam int DEF_BUFFER_BYTES = 65536;

    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 17;
    localparam int RATE_W  = 18;
    localparam int CHAN_W  = 4;
    localparam int BLOCK_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_PULL     = 2'd1,
        REQ_REG_READ = 2'd2,
        REQ_INIT     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_SILENCE = 2'd2,
        ST_BAD_REG = 2'd3
    } status_t;

    // register numbers on the read side
    localparam logic [2:0] RD_RATE    = 3'd0;
    localparam logic [2:0] RD_CHANNEL = 3'd1;
    localparam logic [2:0] RD_BLOCK   = 3'd2;
    localparam logic [2:0] RD_SIZE    = 3'd3;
    localparam logic [2:0] RD_STARTED = 3'd4;
    localparam logic [2:0] RD_LEVEL   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK   = 2'd2;

    // result waiting for the buffer read data
    typedef struct packed {
        logic                pull_hit;
        logic [DATA_W-1:0]   data;
        logic [LEVEL_W-1:0]  level;
        status_t             status;
        logic                last;
    } pend_t;

endpackage

`default_nettype wire

/* sv/audio_sample_fifo_controller_core.sv */
`default_nettype none

// Audio sample ring buffer. Each accepted word (producer byte write, consumer
// pull, register read or init write) yields one result word, and a new word
// can be accepted every cycle while the result side keeps up: the buffer is a
// single memory with one write and one registered read port, so a pull issues
// its read in the accept cycle and the byte joins the result in the output
// register. A write and a later pull of the same entry land in different
// cycles, so no forwarding is needed. The memory is never cleared; only bytes
// that were written are ever pulled. Configuration writes are always ready.

module audio_sample_fifo_controller_core import asfc_pkg::*; #(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_req_type,
    input  wire logic [7:0]            s_sample_byte,
    input  wire logic [2:0]            s_reg_index,
    input  wire logic                  s_burst_last,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_W-1:0]          m_out_data,
    output logic [LEVEL_W-1:0]         m_fill_level,
    output logic [1:0]                 m_status,
    output logic                       m_last_out,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W  = $clog2(BUFFER_BYTES);
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(BUFFER_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUFFER_BYTES);

    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               playing_reg, playing_next;

    logic [RATE_W-1:0]  rate_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [BLOCK_W-1:0] block_reg;

    logic               pend_valid_reg;
    pend_t              pend_reg, pend_next;

    logic               m_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic               advance;
    logic               accept;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rd_data;
    req_t               req;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !pend_valid_reg || advance;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign req       = req_t'(s_req_type);

    always_comb begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        playing_next   = playing_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        pend_next.pull_hit = 1'b0;
        pend_next.data     = '0;
        pend_next.status   = ST_OK;
        pend_next.last     = s_burst_last;
        case (req)
            REQ_WRITE: begin
                if (fill_reg == FILL_MAX) begin
                    pend_next.status = ST_DROPPED;
                end else begin
                    ram_we      = accept;
                    wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    fill_next   = fill_reg + 1'b1;
                end
            end
            REQ_PULL: begin
                if (!playing_reg || fill_reg == '0) begin
                    pend_next.status = ST_SILENCE;
                end else begin
                    ram_re             = accept;
                    pend_next.pull_hit = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    fill_next   = fill_reg - 1'b1;
                end
            end
            REQ_REG_READ: begin
                case (s_reg_index)
                    RD_RATE:    pend_next.data = DATA_W'(rate_reg);
                    RD_CHANNEL: pend_next.data = DATA_W'(chan_reg);
                    RD_BLOCK:   pend_next.data = DATA_W'(block_reg);
                    RD_SIZE:    pend_next.data = DATA_W'(BUFFER_BYTES);
                    RD_STARTED: pend_next.data = DATA_W'(playing_reg);
                    RD_LEVEL:   pend_next.data = DATA_W'(fill_reg);
                    default:    pend_next.status = ST_BAD_REG;
                endcase
            end
            REQ_INIT: begin
                playing_next = 1'b1;
            end
            default: begin
                pend_next.status = ST_OK;
            end
        endcase
        // level is the low bits of the count, zero extended when the ring is small
        pend_next.level = LEVEL_W'(DATA_W'(fill_next));
    end

    asfc_ram #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_sample_byte),
        .rd_en   (ram_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            playing_reg    <= 1'b0;
            rate_reg       <= '0;
            chan_reg       <= '0;
            block_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                rd_ptr_reg  <= rd_ptr_next;
                wr_ptr_reg  <= wr_ptr_next;
                fill_reg    <= fill_next;
                playing_reg <= playing_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RATE:    rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_CHANNEL: chan_reg  <= cfg_data[CHAN_W-1:0];
                    CFG_BLOCK:   block_reg <= cfg_data[BLOCK_W-1:0];
                    default:     rate_reg  <= rate_reg;
                endcase
            end
            if (accept) begin
                pend_valid_reg <= 1'b1;
            end else if (advance) begin
                pend_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
        if (advance && pend_valid_reg) begin
            out_data_reg   <= pend_reg.pull_hit ? DATA_W'(ram_rd_data) : pend_reg.data;
            out_level_reg  <= pend_reg.level;
            out_status_reg <= pend_reg.status;
            out_last_reg   <= pend_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_data   = out_data_reg;
    assign m_fill_level = out_level_reg;
    assign m_status     = out_status_reg;
    assign m_last_out   = out_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count above ring size");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req == REQ_WRITE && fill_reg == FILL_MAX) |=> $stable(fill_reg)
            && $stable(wr_ptr_reg))
        else $error("write into full ring changed state");

    a_silence_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg == ST_SILENCE) |-> out_data_reg == '0)
        else $error("silence result with nonzero data");

    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !advance) |=> pend_valid_reg)
        else $error("pending result lost while output stalled");

    a_playing_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |=> playing_reg)
        else $error("playback flag cleared");

endmodule

`default_nettype wire

/* sv/asfc_ram.sv */
`default_nettype none

module asfc_ram import asfc_pkg::*; #(
    parameter int DEPTH  = DEF_BUFFER_BYTES,
    parameter int ADDR_W = $clog2(DEF_BUFFER_BYTES)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* test/audio_sample_fifo_controller_core_test.sv */
`timescale 1ns / 1ps

module audio_sample_fifo_controller_core_test import asfc_pkg::*;;

    localparam int RING_BYTES  = DEF_BUFFER_BYTES;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_WORDS = 275;

    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] RD_BAD_LO = 3'd6;
    localparam logic [2:0] RD_BAD_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [LEVEL_W-1:0] level;
        status_t            status;
        logic               last;
    } audio_result_t;

    class ring_scoreboard;
        logic [7:0]        ring_mem [RING_BYTES];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       held;
        bit                started;
        logic [RATE_W-1:0]  rate;
        logic [CHAN_W-1:0]  chans;
        logic [BLOCK_W-1:0] block_len;
        audio_result_t     due_q [$];
        int                errors;

        function new();
            head = 0;
            tail = 0;
            held = 0;
            started = 0;
            rate = '0;
            chans = '0;
            block_len = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RATE:    rate = value[RATE_W-1:0];
                CFG_CHANNEL: chans = value[CHAN_W-1:0];
                CFG_BLOCK:   block_len = value[BLOCK_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the ring model by one accepted word and queue its result
        function void note_word(req_t kind, logic [7:0] sample, logic [2:0] reg_no,
                                logic last);
            audio_result_t r;
            r.data = '0;
            r.status = ST_OK;
            r.last = last;
            case (kind)
                REQ_WRITE: begin
                    if (held >= RING_BYTES) begin
                        r.status = ST_DROPPED;
                    end else begin
                        ring_mem[tail] = sample;
                        tail = (tail + 1) % RING_BYTES;
                        held++;
                    end
                end
                REQ_PULL: begin
                    if (!started || held == 0) begin
                        r.status = ST_SILENCE;
                    end else begin
                        r.data = 32'(ring_mem[head]);
                        head = (head + 1) % RING_BYTES;
                        held--;
                    end
                end
                REQ_REG_READ: begin
                    case (reg_no)
                        RD_RATE:    r.data = 32'(rate);
                        RD_CHANNEL: r.data = 32'(chans);
                        RD_BLOCK:   r.data = 32'(block_len);
                        RD_SIZE:    r.data = 32'(RING_BYTES);
                        RD_STARTED: r.data = 32'(started);
                        RD_LEVEL:   r.data = 32'(held);
                        default:    r.status = ST_BAD_REG;
                    endcase
                end
                REQ_INIT: started = 1;
                default: ;
            endcase
            r.level = held[LEVEL_W-1:0];
            due_q.push_back(r);
        endfunction

        function void check_word(audio_result_t got);
            audio_result_t want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: data %h level %0d status %0d last %b",
                             got.data, got.level, got.status, got.last);
                return;
            end
            want = due_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"result mismatch: want data %h level %0d status %0d last %b, ",
                              "got data %h level %0d status %0d last %b"},
                             want.data, want.level, want.status, want.last,
                             got.data, got.level, got.status, got.last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    req_t                  s_req_type = REQ_WRITE;
    logic [7:0]            s_sample_byte = '0;
    logic [2:0]            s_reg_index = '0;
    logic                  s_burst_last = 1'b0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DATA_W-1:0]     m_out_data;
    logic [LEVEL_W-1:0]    m_fill_level;
    logic [1:0]            m_status;
    logic                  m_last_out;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    src_idle = 0;
    int                    sink_stall = 0;
    int                    cycles = 0;
    ring_scoreboard        sb;

    audio_sample_fifo_controller_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_sample_byte (s_sample_byte),
        .s_reg_index   (s_reg_index),
        .s_burst_last  (s_burst_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_data    (m_out_data),
        .m_fill_level  (m_fill_level),
        .m_status      (m_status),
        .m_last_out    (m_last_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall);
        if (m_valid && m_ready)
            sb.check_word({m_out_data, m_fill_level, m_status, m_last_out});
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("audio_sample_fifo_controller_core_test: errors");
        $finish;
    end

    task automatic send_word(req_t kind, logic [7:0] sample, logic [2:0] reg_no, logic last);
        if ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_sample_byte <= sample;
        s_reg_index   <= reg_no;
        s_burst_last  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(kind, sample, reg_no, last);
    endtask

    task automatic send_random_word();
        int   pick;
        req_t kind;
        pick = $urandom_range(99);
        if (pick < 40)      kind = REQ_WRITE;
        else if (pick < 80) kind = REQ_PULL;
        else if (pick < 95) kind = REQ_REG_READ;
        else                kind = REQ_INIT;
        send_word(kind, 8'($urandom), 3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_settings(logic [CFG_DATA_W-1:0] rate_v, logic [CFG_DATA_W-1:0] chan_v,
                                 logic [CFG_DATA_W-1:0] block_v,
                                 logic [CFG_DATA_W-1:0] spare_v);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idxs [4];
        vals = '{rate_v, chan_v, block_v, spare_v};
        idxs = '{CFG_RATE, CFG_CHANNEL, CFG_BLOCK, CFG_SPARE};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int src_tab [4];
        int sink_tab [4];
        src_tab = '{0, 66, 0, 6};
        sink_tab = '{0, 0, 66, 6};
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, silence before start, bad registers, repeated init
        send_word(REQ_REG_READ, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_CHANNEL, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_BLOCK, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_STARTED, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_LEVEL, 1'b1);
        send_word(REQ_PULL, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_WRITE, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_WRITE, 8'hFF, RD_BAD_HI, 1'b1);
        send_word(REQ_WRITE, 8'hA5, RD_RATE, 1'b0);
        send_word(REQ_PULL, 8'hFF, RD_RATE, 1'b1);
        send_word(REQ_REG_READ, 8'h00, RD_SIZE, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_BAD_LO, 1'b1);
        send_word(REQ_REG_READ, 8'hFF, RD_BAD_HI, 1'b0);
        send_word(REQ_INIT, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_STARTED, 1'b0);
        send_word(REQ_INIT, 8'hFF, RD_BAD_HI, 1'b1);
        send_word(REQ_PULL, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_PULL, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_PULL, 8'h00, RD_RATE, 1'b1);
        send_word(REQ_PULL, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_LEVEL, 1'b1);
        drain_results();

        load_settings(32'd192000, 32'd8, 32'd65535, 32'hFFFF_FFFF);
        send_word(REQ_REG_READ, 8'h00, RD_RATE, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_CHANNEL, 1'b0);
        send_word(REQ_REG_READ, 8'h00, RD_BLOCK, 1'b1);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: load_settings(32'($urandom_range(192000)), 32'($urandom_range(8)),
                                 32'($urandom_range(65535)), $urandom);
                1: load_settings('1, '1, '1, '1);
                2: load_settings('0, '0, '0, '0);
                default: load_settings($urandom, $urandom, $urandom, $urandom);
            endcase
            src_idle = src_tab[phase];
            sink_stall = sink_tab[phase];
            repeat (PHASE_WORDS) send_random_word();
            drain_results();
        end

        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("audio_sample_fifo_controller_core_test: clean");
        else
            $display("audio_sample_fifo_controller_core_test: errors");
        $finish;
    end

endmodule
